// ===== sv/ps2dec_pkg.sv =====
// Shared types, event codes and scan code tables for the PS/2 set 2 decoder.
// No dependencies; imported by ps2_set2_scancode_decoder_top and the testbench.
package ps2dec_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_led;

    // event kinds
    localparam t_kind KIND_MAKE        = 3'd0;
    localparam t_kind KIND_BREAK       = 3'd1;
    localparam t_kind KIND_PRTSC_MAKE  = 3'd2;
    localparam t_kind KIND_PRTSC_BREAK = 3'd3;
    localparam t_kind KIND_PAUSE       = 3'd4;
    localparam t_kind KIND_SYSRQ       = 3'd5;
    localparam t_kind KIND_UNKNOWN     = 3'd6;

    // LED bits
    localparam t_led LED_SCROLL = 3'b001;
    localparam t_led LED_NUM    = 3'b010;
    localparam t_led LED_CAPS   = 3'b100;

    // special bytes
    localparam t_byte SC_ESCAPE  = 8'he0;
    localparam t_byte SC_PAUSE   = 8'he1;
    localparam t_byte SC_BREAK   = 8'hf0;
    localparam t_byte SC_SYSRQ   = 8'h84;
    localparam t_byte SC_LSHIFT  = 8'h12;
    localparam t_byte SC_KPSTAR  = 8'h7c;
    localparam t_byte SC_LCTRL   = 8'h14;
    localparam t_byte SC_NUMLOCK = 8'h77;
    localparam t_byte SC_SCROLL  = 8'h7e;
    localparam t_byte SC_CAPS    = 8'h58;

    // result of decoding one byte
    typedef struct packed {
        logic  emit;
        t_kind kind;
        logic  esc;
        logic  upd;
    } t_dec_result;

    // device command responses, never key data
    function automatic logic is_response(input t_byte b);
        logic r;
        case (b) inside
            8'h00, 8'haa, 8'hee, 8'hfa, 8'hfc, 8'hfd, 8'hfe, 8'hff: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_plain_key(input t_byte b);
        logic r;
        unique case (b) inside
            8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0c,
            8'h0d, 8'h0e, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h1a, 8'h1b, 8'h1c,
            8'h1d, 8'h1e, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2a,
            8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
            8'h36, 8'h37, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h41, 8'h42,
            8'h43, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e,
            8'h52, 8'h54, 8'h55, 8'h58, 8'h59, 8'h5a, 8'h5b, 8'h5d, 8'h61, 8'h66,
            8'h69, 8'h6b, 8'h6c, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76,
            8'h77, 8'h78, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7d, 8'h7e, 8'h83: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_escaped_key(input t_byte b);
        logic r;
        unique case (b) inside
            8'h10, 8'h11, 8'h14, 8'h15, 8'h1f, 8'h20, 8'h21, 8'h23, 8'h27, 8'h28,
            8'h2b, 8'h2f, 8'h30, 8'h32, 8'h34, 8'h37, 8'h38, 8'h3b, 8'h3f, 8'h48,
            8'h4a, 8'h4d, 8'h50, 8'h5a, 8'h5e, 8'h69, 8'h6b, 8'h6c, 8'h70, 8'h71,
            8'h72, 8'h74, 8'h75, 8'h7a, 8'h7d: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // expected byte at Pause sequence positions 1..7
    function automatic t_byte pause_expect(input logic [2:0] pos);
        t_byte r;
        unique case (pos)
            3'd1:    r = SC_LCTRL;
            3'd2:    r = SC_NUMLOCK;
            3'd3:    r = SC_PAUSE;
            3'd4:    r = SC_BREAK;
            3'd5:    r = SC_LCTRL;
            3'd6:    r = SC_BREAK;
            3'd7:    r = SC_NUMLOCK;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/ps2_set2_scancode_decoder_top.sv =====
// PS/2 scan code set 2 decoder, top level.
// Depends on ps2dec_pkg (types, event codes, key tables).
//
// Usage
//   Scan channel  (i_scan_valid / o_scan_ready / i_scan_byte): one byte per
//   transaction, as received from the keyboard port.
//   Event channel (o_evt_valid / i_evt_ready / event fields): at most one event
//   per byte; bytes that are prefixes, sequence members or command responses
//   produce nothing.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_keyboard_enable): writes
//   the enable bit; always ready. Write only while the block is idle.
// Timing
//   Byte enters the input register at its transaction edge and is decoded
//   there against the sequence state; any event is then loaded into the output
//   register, which drives o_evt_valid. One byte per cycle sustained while no
//   event is held up there, a rate set by the single decode stage.
// Stalls
//   While the output register holds an unaccepted event, bytes that yield no
//   event still pass through; a byte that yields one waits in the input register
//   and o_scan_ready drops only then.
// Reset
//   Synchronous, active low: sequence trackers cleared, enable set, Num Lock LED on.
module ps2_set2_scancode_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_scan_valid,
    output logic               o_scan_ready,
    input  ps2dec_pkg::t_byte  i_scan_byte,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_keyboard_enable,
    output logic               o_evt_valid,
    input  logic               i_evt_ready,
    output ps2dec_pkg::t_kind  o_event_kind,
    output logic               o_key_escaped,
    output ps2dec_pkg::t_byte  o_key_byte,
    output ps2dec_pkg::t_led   o_led_bits,
    output logic               o_led_update
);
    import ps2dec_pkg::*;

    // input stage
    logic        r_in_valid;
    t_byte       r_in_byte;

    // decoder state
    logic        r_kbd_enable;
    logic        r_escape_seen, n_escape_seen;
    logic        r_break_seen,  n_break_seen;
    logic [1:0]  r_prtsc_make_pos,  n_prtsc_make_pos;
    logic [2:0]  r_prtsc_break_pos, n_prtsc_break_pos;
    logic [2:0]  r_pause_pos, n_pause_pos;
    t_led        r_led_state, n_led_state;

    // output stage
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic        r_out_esc;
    t_byte       r_out_byte;
    t_led        r_out_led;
    logic        r_out_upd;

    t_dec_result w_dec;
    logic        w_known;
    logic        w_done;
    logic        w_out_free;
    logic        w_dec_fire;

    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Decode of the byte in the input register against the current state.
    // Follows the priority: enable and response filter, PrtSc make tracker, PrtSc break
    // tracker, Pause tracker, prefixes, SysRq, table lookup.
    // ---------------------------------------------------------------------
    always_comb begin
        n_escape_seen     = r_escape_seen;
        n_break_seen      = r_break_seen;
        n_prtsc_make_pos  = r_prtsc_make_pos;
        n_prtsc_break_pos = r_prtsc_break_pos;
        n_pause_pos       = r_pause_pos;
        n_led_state       = r_led_state;
        w_dec             = '0;
        w_known           = 1'b0;
        w_done            = 1'b0;

        if (!r_kbd_enable || is_response(r_in_byte)) begin
            w_done = 1'b1;
        end

        // Print Screen make: E0 12 E0 7C
        if (!w_done) begin
            case (r_prtsc_make_pos)
                2'd1: begin
                    if (r_in_byte == SC_LSHIFT) begin
                        n_prtsc_make_pos = 2'd2;
                        n_escape_seen    = 1'b0;
                        w_done           = 1'b1;
                    end else begin
                        n_prtsc_make_pos = 2'd0;
                    end
                end
                2'd2: begin
                    if (r_in_byte == SC_ESCAPE) begin
                        n_prtsc_make_pos = 2'd3;
                        w_done           = 1'b1;
                    end else begin
                        n_prtsc_make_pos = 2'd0;
                    end
                end
                2'd3: begin
                    n_prtsc_make_pos = 2'd0;
                    if (r_in_byte == SC_KPSTAR) begin
                        w_dec.emit = 1'b1;
                        w_dec.kind = KIND_PRTSC_MAKE;
                        w_done     = 1'b1;
                    end
                end
                default: n_prtsc_make_pos = 2'd0;
            endcase
        end

        // Print Screen break: E0 F0 7C E0 F0 12
        if (!w_done) begin
            case (r_prtsc_break_pos)
                3'd1: begin
                    if (r_in_byte == SC_BREAK) begin
                        n_prtsc_break_pos = 3'd2;
                        n_break_seen      = 1'b1;
                    end else begin
                        n_prtsc_break_pos = 3'd0;
                    end
                end
                3'd2: begin
                    if (r_in_byte == SC_KPSTAR) begin
                        n_prtsc_break_pos = 3'd3;
                        w_done            = 1'b1;
                    end else begin
                        n_prtsc_break_pos = 3'd0;
                    end
                end
                3'd3: begin
                    if (r_in_byte == SC_ESCAPE) begin
                        n_prtsc_break_pos = 3'd4;
                        w_done            = 1'b1;
                    end else begin
                        n_prtsc_break_pos = 3'd0;
                        n_escape_seen     = 1'b0;
                        n_break_seen      = 1'b0;
                    end
                end
                3'd4: begin
                    if (r_in_byte == SC_BREAK) begin
                        n_prtsc_break_pos = 3'd5;
                        w_done            = 1'b1;
                    end else begin
                        n_prtsc_break_pos = 3'd0;
                    end
                end
                3'd5: begin
                    n_prtsc_break_pos = 3'd0;
                    if (r_in_byte == SC_LSHIFT) begin
                        n_escape_seen = 1'b0;
                        n_break_seen  = 1'b0;
                        w_dec.emit    = 1'b1;
                        w_dec.kind    = KIND_PRTSC_BREAK;
                        w_done        = 1'b1;
                    end
                end
                default: n_prtsc_break_pos = 3'd0;
            endcase
        end

        // Pause: E1 14 77 E1 F0 14 F0 77; a mismatch swallows the byte
        if (!w_done && (r_pause_pos != 3'd0)) begin
            w_done = 1'b1;
            if (r_in_byte != pause_expect(r_pause_pos)) begin
                n_pause_pos = 3'd0;
            end else if (r_pause_pos == 3'd7) begin
                n_pause_pos = 3'd0;
                w_dec.emit  = 1'b1;
                w_dec.kind  = KIND_PAUSE;
            end else begin
                n_pause_pos = r_pause_pos + 3'd1;
            end
        end

        if (!w_done) begin
            if (r_in_byte == SC_ESCAPE) begin
                n_escape_seen     = 1'b1;
                n_prtsc_make_pos  = 2'd1;
                n_prtsc_break_pos = 3'd1;
            end else if (r_in_byte == SC_PAUSE) begin
                n_pause_pos = 3'd1;
            end else if (r_in_byte == SC_BREAK) begin
                n_break_seen = 1'b1;
            end else if (r_in_byte == SC_SYSRQ) begin
                // SysRq under a break prefix is dropped; prefixes are kept
                if (!n_break_seen) begin
                    w_dec.emit = 1'b1;
                    w_dec.kind = KIND_SYSRQ;
                end
            end else begin
                w_dec.esc = n_escape_seen;
                w_known   = n_escape_seen ? is_escaped_key(r_in_byte)
                                          : is_plain_key(r_in_byte);
                w_dec.emit = 1'b1;
                if (!w_known) begin
                    w_dec.kind = KIND_UNKNOWN;
                end else begin
                    w_dec.kind = n_break_seen ? KIND_BREAK : KIND_MAKE;
                    if (!n_escape_seen && !n_break_seen) begin
                        if (r_in_byte == SC_NUMLOCK) begin
                            n_led_state = r_led_state ^ LED_NUM;
                            w_dec.upd   = 1'b1;
                        end else if (r_in_byte == SC_SCROLL) begin
                            n_led_state = r_led_state ^ LED_SCROLL;
                            w_dec.upd   = 1'b1;
                        end else if (r_in_byte == SC_CAPS) begin
                            n_led_state = r_led_state ^ LED_CAPS;
                            w_dec.upd   = 1'b1;
                        end
                    end
                end
                // any finished key, known or not, ends all sequences
                n_escape_seen     = 1'b0;
                n_break_seen      = 1'b0;
                n_prtsc_make_pos  = 2'd0;
                n_prtsc_break_pos = 3'd0;
                n_pause_pos       = 3'd0;
            end
        end
    end

    // Handshake: output register frees when empty or taken; a byte with no
    // event never waits on the event side.
    assign w_out_free   = !r_out_valid || i_evt_ready;
    assign w_dec_fire   = r_in_valid && (!w_dec.emit || w_out_free);
    assign o_scan_ready = !r_in_valid || w_dec_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_kbd_enable      <= 1'b1;
            r_escape_seen     <= 1'b0;
            r_break_seen      <= 1'b0;
            r_prtsc_make_pos  <= 2'd0;
            r_prtsc_break_pos <= 3'd0;
            r_pause_pos       <= 3'd0;
            r_led_state       <= LED_NUM;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_kbd_enable <= i_cfg_keyboard_enable;
            end
            if (o_scan_ready) begin
                r_in_valid <= i_scan_valid;
            end
            if (w_dec_fire) begin
                r_escape_seen     <= n_escape_seen;
                r_break_seen      <= n_break_seen;
                r_prtsc_make_pos  <= n_prtsc_make_pos;
                r_prtsc_break_pos <= n_prtsc_break_pos;
                r_pause_pos       <= n_pause_pos;
                r_led_state       <= n_led_state;
            end
            if (w_out_free) begin
                r_out_valid <= w_dec_fire && w_dec.emit;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_scan_ready && i_scan_valid) begin
            r_in_byte <= i_scan_byte;
        end
        if (w_dec_fire && w_dec.emit) begin
            r_out_kind <= w_dec.kind;
            r_out_esc  <= w_dec.esc;
            r_out_byte <= r_in_byte;
            r_out_led  <= n_led_state;
            r_out_upd  <= w_dec.upd;
        end
    end

    assign o_evt_valid   = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_key_escaped = r_out_esc;
    assign o_key_byte    = r_out_byte;
    assign o_led_bits    = r_out_led;
    assign o_led_update  = r_out_upd;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_esc_only_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_key_escaped) |->
            (r_out_kind == KIND_MAKE || r_out_kind == KIND_BREAK ||
             r_out_kind == KIND_UNKNOWN))
        else $error("escaped flag on a non-key event");

    a_led_upd_on_make: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_led_update) |-> (r_out_kind == KIND_MAKE && !o_key_escaped))
        else $error("LED update on an event other than a plain make");

    a_disabled_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_kbd_enable) |-> !w_dec.emit)
        else $error("event decoded while keyboard disabled");

    a_pause_excl_prtsc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pause_pos != 3'd0) |-> (r_prtsc_make_pos == 2'd0))
        else $error("Pause and Print Screen make tracked together");

endmodule

// ===== tb/ps2_set2_event_checker.sv =====
`timescale 1ns / 100ps
// Event checker for the PS/2 set 2 scan code decoder: follows the scan, config and
// event channels, predicts each event and compares it field by field.
// Depends on ps2dec_pkg for types, event kinds, LED masks and special bytes.
module ps2_set2_event_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_scan_valid,
    input  logic              i_scan_ready,
    input  ps2dec_pkg::t_byte i_scan_byte,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_keyboard_enable,
    input  logic              i_evt_valid,
    input  logic              i_evt_ready,
    input  ps2dec_pkg::t_kind i_event_kind,
    input  logic              i_key_escaped,
    input  ps2dec_pkg::t_byte i_key_byte,
    input  ps2dec_pkg::t_led  i_led_bits,
    input  logic              i_led_update,
    output int                o_fail_count,
    output int                o_pending
);
    import ps2dec_pkg::*;

    typedef struct packed {
        t_kind kind;
        logic  escaped;
        t_byte key;
        t_led  leds;
        logic  led_upd;
    } t_key_event;

    localparam int PLAIN_COUNT = 89;
    localparam int ESC_COUNT   = 35;

    localparam logic [8*PLAIN_COUNT-1:0] PLAIN_KEYS = {
        8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0c,
        8'h0d, 8'h0e, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h1a, 8'h1b, 8'h1c,
        8'h1d, 8'h1e, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2a,
        8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
        8'h36, 8'h37, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h41, 8'h42,
        8'h43, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e,
        8'h52, 8'h54, 8'h55, 8'h58, 8'h59, 8'h5a, 8'h5b, 8'h5d, 8'h61, 8'h66,
        8'h69, 8'h6b, 8'h6c, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76,
        8'h77, 8'h78, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7d, 8'h7e, 8'h83
    };

    localparam logic [8*ESC_COUNT-1:0] ESC_KEYS = {
        8'h10, 8'h11, 8'h14, 8'h15, 8'h1f, 8'h20, 8'h21, 8'h23, 8'h27, 8'h28,
        8'h2b, 8'h2f, 8'h30, 8'h32, 8'h34, 8'h37, 8'h38, 8'h3b, 8'h3f, 8'h48,
        8'h4a, 8'h4d, 8'h50, 8'h5a, 8'h5e, 8'h69, 8'h6b, 8'h6c, 8'h70, 8'h71,
        8'h72, 8'h74, 8'h75, 8'h7a, 8'h7d
    };

    // predicted decoder state
    logic       enabled;
    logic       esc_pending;
    logic       brk_pending;
    logic [1:0] psm_step;
    logic [2:0] psb_step;
    logic [2:0] pause_step;
    t_led       lock_leds;

    t_key_event expected_events[$];

    function automatic logic is_reply_byte(input t_byte b);
        return b == 8'h00 || b == 8'haa || b == 8'hee || b == 8'hfa ||
               b == 8'hfc || b == 8'hfd || b == 8'hfe || b == 8'hff;
    endfunction

    function automatic logic key_known(input logic esc, input t_byte b);
        logic hit;
        hit = 1'b0;
        if (esc) begin
            for (int i = 0; i < ESC_COUNT; i++)
                if (ESC_KEYS[8*i +: 8] == b) hit = 1'b1;
        end else begin
            for (int i = 0; i < PLAIN_COUNT; i++)
                if (PLAIN_KEYS[8*i +: 8] == b) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void clear_prefixes();
        esc_pending = 1'b0;
        brk_pending = 1'b0;
        psm_step    = 2'd0;
        psb_step    = 3'd0;
        pause_step  = 3'd0;
    endfunction

    function automatic t_key_event as_event(input t_kind kind, input logic esc,
                                            input t_byte b, input logic upd);
        t_key_event ev;
        ev.kind    = kind;
        ev.escaped = esc;
        ev.key     = b;
        ev.leds    = lock_leds;
        ev.led_upd = upd;
        return ev;
    endfunction

    // Returns 1 when the byte completes an event; state is advanced either way.
    function automatic logic decode_scan_byte(input t_byte b, output t_key_event ev);
        logic  esc;
        logic  known;
        logic  upd;
        t_byte want;
        ev  = '0;
        upd = 1'b0;
        if (!enabled || is_reply_byte(b)) return 1'b0;

        // print screen make: E0 12 E0 7C
        case (psm_step)
            2'd1: begin
                if (b == SC_LSHIFT) begin
                    psm_step    = 2'd2;
                    esc_pending = 1'b0;
                    return 1'b0;
                end
                psm_step = 2'd0;
            end
            2'd2: begin
                if (b == SC_ESCAPE) begin
                    psm_step = 2'd3;
                    return 1'b0;
                end
                psm_step = 2'd0;
            end
            2'd3: begin
                psm_step = 2'd0;
                if (b == SC_KPSTAR) begin
                    ev = as_event(KIND_PRTSC_MAKE, 1'b0, b, 1'b0);
                    return 1'b1;
                end
            end
            default: psm_step = 2'd0;
        endcase

        // print screen break: E0 F0 7C E0 F0 12
        case (psb_step)
            3'd1: begin
                if (b == SC_BREAK) begin
                    psb_step    = 3'd2;
                    brk_pending = 1'b1;
                end else begin
                    psb_step = 3'd0;
                end
            end
            3'd2: begin
                if (b == SC_KPSTAR) begin
                    psb_step = 3'd3;
                    return 1'b0;
                end
                psb_step = 3'd0;
            end
            3'd3: begin
                if (b == SC_ESCAPE) begin
                    psb_step = 3'd4;
                    return 1'b0;
                end
                psb_step    = 3'd0;
                esc_pending = 1'b0;
                brk_pending = 1'b0;
            end
            3'd4: begin
                if (b == SC_BREAK) begin
                    psb_step = 3'd5;
                    return 1'b0;
                end
                psb_step = 3'd0;
            end
            3'd5: begin
                psb_step = 3'd0;
                if (b == SC_LSHIFT) begin
                    esc_pending = 1'b0;
                    brk_pending = 1'b0;
                    ev = as_event(KIND_PRTSC_BREAK, 1'b0, b, 1'b0);
                    return 1'b1;
                end
            end
            default: psb_step = 3'd0;
        endcase

        // pause: E1 14 77 E1 F0 14 F0 77, a wrong byte is swallowed
        if (pause_step != 3'd0) begin
            case (pause_step)
                3'd1, 3'd5: want = SC_LCTRL;
                3'd2, 3'd7: want = SC_NUMLOCK;
                3'd3:       want = SC_PAUSE;
                default:    want = SC_BREAK;
            endcase
            if (b != want) begin
                pause_step = 3'd0;
                return 1'b0;
            end
            if (pause_step == 3'd7) begin
                pause_step = 3'd0;
                ev = as_event(KIND_PAUSE, 1'b0, b, 1'b0);
                return 1'b1;
            end
            pause_step = pause_step + 3'd1;
            return 1'b0;
        end

        if (b == SC_ESCAPE) begin
            esc_pending = 1'b1;
            psm_step    = 2'd1;
            psb_step    = 3'd1;
            return 1'b0;
        end
        if (b == SC_PAUSE) begin
            pause_step = 3'd1;
            return 1'b0;
        end
        if (b == SC_BREAK) begin
            brk_pending = 1'b1;
            return 1'b0;
        end
        if (b == SC_SYSRQ) begin
            if (brk_pending) return 1'b0;
            ev = as_event(KIND_SYSRQ, 1'b0, b, 1'b0);
            return 1'b1;
        end

        esc         = esc_pending;
        known       = key_known(esc, b);
        esc_pending = 1'b0;
        if (!known) begin
            clear_prefixes();
            ev = as_event(KIND_UNKNOWN, esc, b, 1'b0);
            return 1'b1;
        end

        // lock keys toggle on plain make only
        if (!esc && !brk_pending) begin
            case (b)
                SC_NUMLOCK: begin
                    lock_leds = lock_leds ^ LED_NUM;
                    upd = 1'b1;
                end
                SC_SCROLL: begin
                    lock_leds = lock_leds ^ LED_SCROLL;
                    upd = 1'b1;
                end
                SC_CAPS: begin
                    lock_leds = lock_leds ^ LED_CAPS;
                    upd = 1'b1;
                end
                default: upd = 1'b0;
            endcase
        end
        ev = as_event(brk_pending ? KIND_BREAK : KIND_MAKE, esc, b, upd);
        clear_prefixes();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_key_event want;
        t_key_event predicted;
        if (!i_rst_n) begin
            enabled   = 1'b1;
            lock_leds = LED_NUM;
            clear_prefixes();
            expected_events.delete();
        end else begin
            // an event leaving now belongs to an earlier byte, so check first
            if (i_evt_valid && i_evt_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected event: kind %0d, byte %02h", i_event_kind, i_key_byte);
                    o_fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (i_event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind, i_event_kind);
                        o_fail_count++;
                    end
                    if (i_key_escaped !== want.escaped) begin
                        $error("key_escaped: expected %0d, got %0d", want.escaped,
                               i_key_escaped);
                        o_fail_count++;
                    end
                    if (i_key_byte !== want.key) begin
                        $error("key_byte: expected %02h, got %02h", want.key, i_key_byte);
                        o_fail_count++;
                    end
                    if (i_led_bits !== want.leds) begin
                        $error("led_bits: expected %0d, got %0d", want.leds, i_led_bits);
                        o_fail_count++;
                    end
                    if (i_led_update !== want.led_upd) begin
                        $error("led_update: expected %0d, got %0d", want.led_upd,
                               i_led_update);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                enabled = i_cfg_keyboard_enable;
            if (i_scan_valid && i_scan_ready) begin
                if (decode_scan_byte(i_scan_byte, predicted))
                    expected_events.push_back(predicted);
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// ===== tb/ps2_set2_scancode_decoder_top_test.sv =====
`timescale 1ns / 100ps
// Top of the PS/2 set 2 decoder testbench: clock, reset, byte stimulus, event sink
// and verdict. Depends on ps2dec_pkg, ps2_set2_scancode_decoder_top and the checker.
module ps2_set2_scancode_decoder_top_test;
    import ps2dec_pkg::*;

    localparam int RESET_CYCLES   = 8;
    // margin after the last owed event for any byte still in flight
    localparam int DRAIN_CYCLES   = 4;
    localparam int ENABLED_BYTES  = 960;
    localparam int DISABLED_BYTES = 60;
    // far beyond the slowest legal run: ~1.1k bytes, each with the largest random
    // idle gap on the sender plus the largest random stall on the sink
    localparam int TIMEOUT_NS     = 2_000_000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_scan_valid;
    logic  o_scan_ready;
    t_byte i_scan_byte;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    logic  i_cfg_keyboard_enable;
    logic  o_evt_valid;
    logic  i_evt_ready;
    t_kind o_event_kind;
    logic  o_key_escaped;
    t_byte o_key_byte;
    t_led  o_led_bits;
    logic  o_led_update;

    int fail_count;
    int pending;
    int bytes_sent;
    // set during stretches where neither side idles
    bit no_gaps;

    ps2_set2_scancode_decoder_top DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_scan_valid          (i_scan_valid),
        .o_scan_ready          (o_scan_ready),
        .i_scan_byte           (i_scan_byte),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_keyboard_enable (i_cfg_keyboard_enable),
        .o_evt_valid           (o_evt_valid),
        .i_evt_ready           (i_evt_ready),
        .o_event_kind          (o_event_kind),
        .o_key_escaped         (o_key_escaped),
        .o_key_byte            (o_key_byte),
        .o_led_bits            (o_led_bits),
        .o_led_update          (o_led_update)
    );

    // Watches all three channels beside the DUT; reports mismatches itself and
    // hands back the failure count plus the number of events still owed.
    ps2_set2_event_checker u_event_check (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_scan_valid          (i_scan_valid),
        .i_scan_ready          (o_scan_ready),
        .i_scan_byte           (i_scan_byte),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_ready           (o_cfg_ready),
        .i_cfg_keyboard_enable (i_cfg_keyboard_enable),
        .i_evt_valid           (o_evt_valid),
        .i_evt_ready           (i_evt_ready),
        .i_event_kind          (o_event_kind),
        .i_key_escaped         (o_key_escaped),
        .i_key_byte            (o_key_byte),
        .i_led_bits            (o_led_bits),
        .i_led_update          (o_led_update),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    // 4 ns period
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Event sink: before each transaction it may hold ready low for a random stall
    // (none while no_gaps is set), then keeps ready high until an event is taken.
    initial begin : event_sink
        int stall;
        i_evt_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_evt_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_evt_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_evt_valid && i_evt_ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // One scan transaction. Called and left at a falling edge; valid stays
    // high into the next call when that call has no idle gap.
    task automatic send_byte(input t_byte b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_scan_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_scan_valid <= 1'b1;
        i_scan_byte  <= b;
        @(posedge i_clk);
        while (!o_scan_ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Enable writes happen only with the decoder quiet: all owed events
    // taken, then a wait of DRAIN_CYCLES for any byte still in flight with no event.
    task automatic write_enable(input logic en);
        i_scan_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_keyboard_enable <= en;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed key sequences with random keys; the rest is noise
    // and sequences cut short and followed by a stray byte.
    task automatic send_random_sequence();
        t_byte seq[$];
        t_byte whole[$];
        t_byte key_p;
        t_byte key_e;
        t_byte lock_key;
        int    pick;
        int    cut;
        if ($urandom_range(0, 31) == 0) no_gaps = ~no_gaps;
        do key_p = t_byte'($urandom_range(8'h01, 8'h83)); while (!is_plain_key(key_p));
        do key_e = t_byte'($urandom_range(8'h10, 8'h7d)); while (!is_escaped_key(key_e));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            seq = '{key_p};
        end else if (pick < 45) begin
            seq = '{SC_BREAK, key_p};
        end else if (pick < 55) begin
            seq = '{SC_ESCAPE, key_e};
        end else if (pick < 63) begin
            seq = '{SC_ESCAPE, SC_BREAK, key_e};
        end else if (pick < 68) begin
            // lock keys, make or break
            case ($urandom_range(0, 2))
                0:       lock_key = SC_NUMLOCK;
                1:       lock_key = SC_CAPS;
                default: lock_key = SC_SCROLL;
            endcase
            seq = '{lock_key};
            if ($urandom_range(0, 1) == 1) seq.push_front(SC_BREAK);
        end else if (pick < 72) begin
            seq = '{SC_ESCAPE, SC_LSHIFT, SC_ESCAPE, SC_KPSTAR};
        end else if (pick < 76) begin
            seq = '{SC_ESCAPE, SC_BREAK, SC_KPSTAR, SC_ESCAPE, SC_BREAK, SC_LSHIFT};
        end else if (pick < 80) begin
            seq = '{SC_PAUSE, SC_LCTRL, SC_NUMLOCK, SC_PAUSE,
                    SC_BREAK, SC_LCTRL, SC_BREAK, SC_NUMLOCK};
        end else if (pick < 83) begin
            seq = '{SC_SYSRQ};
            if ($urandom_range(0, 1) == 1) seq.push_front(SC_BREAK);
        end else if (pick < 93) begin
            // noise, sometimes behind an escape to reach unknown escaped codes
            if ($urandom_range(0, 1) == 1) seq.push_back(SC_ESCAPE);
            repeat ($urandom_range(1, 2)) seq.push_back(t_byte'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 2))
                0: whole = '{SC_ESCAPE, SC_LSHIFT, SC_ESCAPE, SC_KPSTAR};
                1: whole = '{SC_ESCAPE, SC_BREAK, SC_KPSTAR, SC_ESCAPE, SC_BREAK, SC_LSHIFT};
                default: whole = '{SC_PAUSE, SC_LCTRL, SC_NUMLOCK, SC_PAUSE,
                                   SC_BREAK, SC_LCTRL, SC_BREAK, SC_NUMLOCK};
            endcase
            cut = $urandom_range(1, whole.size() - 1);
            for (int i = 0; i < cut; i++) seq.push_back(whole[i]);
            seq.push_back(t_byte'($urandom_range(0, 255)));
        end
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    initial begin : stimulus
        t_byte directed[$];
        int    target;
        i_rst_n               = 1'b0;
        i_scan_valid          = 1'b0;
        i_scan_byte           = '0;
        i_cfg_valid           = 1'b0;
        i_cfg_keyboard_enable = 1'b0;
        no_gaps               = 1'b0;
        bytes_sent            = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_enable(1'b1);

        // Directed: both response extremes, a lock toggle, an escaped break,
        // the full print screen break, the full pause, sysrq with and without
        // a break prefix (the prefix lingers), then an unknown plain code.
        directed = '{8'h00, 8'hff, SC_NUMLOCK,
                     SC_ESCAPE, SC_BREAK, 8'h75,
                     SC_ESCAPE, SC_BREAK, SC_KPSTAR, SC_ESCAPE, SC_BREAK, SC_LSHIFT,
                     SC_PAUSE, SC_LCTRL, SC_NUMLOCK, SC_PAUSE,
                     SC_BREAK, SC_LCTRL, SC_BREAK, SC_NUMLOCK,
                     SC_SYSRQ, SC_BREAK, SC_SYSRQ, 8'h02};
        foreach (directed[i]) send_byte(directed[i]);

        target = bytes_sent + ENABLED_BYTES / 2;
        while (bytes_sent < target) send_random_sequence();

        // disabled: everything must be swallowed without events
        write_enable(1'b0);
        target = bytes_sent + DISABLED_BYTES;
        while (bytes_sent < target) send_random_sequence();

        write_enable(1'b1);
        target = bytes_sent + ENABLED_BYTES / 2;
        while (bytes_sent < target) send_random_sequence();

        // drain: wait for owed events, then DRAIN_CYCLES for any byte still in flight
        i_scan_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ps2dec_pkg.sv
sv/ps2_set2_scancode_decoder_top.sv
tb/ps2_set2_event_checker.sv
tb/ps2_set2_scancode_decoder_top_test.sv
